// ----- rtl/bflm_pkg.sv -----
// ----------------------------------------------------------------------------
// bflm_pkg
// Types and constants shared by the buffer free list manager modules.
// ----------------------------------------------------------------------------
package bflm_pkg;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 6;
  localparam int IN_W     = 8;
  localparam int OUT_W    = 8;

  localparam logic [OP_W-1:0] OP_INS_HEAD = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
  localparam logic [OP_W-1:0] OP_PEEK     = 2'd3;

  // result word, status in the lowest bit
  typedef struct packed {
    logic             list_empty;
    logic [IDX_W-1:0] head_index;
    logic             status;
  } res_t;

  // write strobes toward the link and membership memories
  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic flag_we;
    logic flag_wd;
  } wr_t;

endpackage

// ----- rtl/buffer_free_list_manager.sv -----
// ----------------------------------------------------------------------------
// buffer_free_list_manager
// Doubly linked free list over a pool of buffer indices.
// ----------------------------------------------------------------------------
// For each request the membership bit and both links of the named buffer
// are read from their memories as it is taken; once the result register
// is free, the links are checked and the updated links written back, and
// only then is a new request taken. After reset the membership memory is
// cleared one entry a cycle, with s_tready low. Insert at head or tail,
// remove any listed buffer, or peek; each request yields one result with
// status, the current head and the empty flag.
module buffer_free_list_manager
  import bflm_pkg::*;
#(
  parameter int NUM_BUFFERS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // opcode[1:0], buffer_index[7:2]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status[0], head_index[6:1], list_empty[7]
);

  localparam int ADDR_W = $clog2(NUM_BUFFERS);

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [IDX_W-1:0]  next_rd;
  logic [IDX_W-1:0]  prev_rd;
  logic              flag_rd;
  logic              out_free;
  logic              res_valid;
  res_t              res;
  wr_t               wr;
  logic [ADDR_W-1:0] next_wa;
  logic [ADDR_W-1:0] prev_wa;
  logic [ADDR_W-1:0] flag_wa;
  logic [IDX_W-1:0]  next_wd;
  logic [IDX_W-1:0]  prev_wd;

  assign rd_en    = s_tvalid && s_tready;
  assign rd_addr  = ADDR_W'(s_tdata[OP_W +: IDX_W]);
  assign out_free = !m_tvalid || m_tready;

  bflm_ctrl #(.NUM_BUFFERS(NUM_BUFFERS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_op    (s_tdata[OP_W-1:0]),
    .req_idx   (s_tdata[OP_W +: IDX_W]),
    .req_ready (s_tready),
    .next_rd   (next_rd),
    .prev_rd   (prev_rd),
    .flag_rd   (flag_rd),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .wr        (wr),
    .next_wa   (next_wa),
    .prev_wa   (prev_wa),
    .flag_wa   (flag_wa),
    .next_wd   (next_wd),
    .prev_wd   (prev_wd)
  );

  bflm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUFFERS)) u_next_ram (
    .clk (clk),
    .we  (wr.next_we),
    .wa  (next_wa),
    .wd  (next_wd),
    .re  (rd_en),
    .ra  (rd_addr),
    .rd  (next_rd)
  );

  bflm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUFFERS)) u_prev_ram (
    .clk (clk),
    .we  (wr.prev_we),
    .wa  (prev_wa),
    .wd  (prev_wd),
    .re  (rd_en),
    .ra  (rd_addr),
    .rd  (prev_rd)
  );

  bflm_ram #(.WIDTH(1), .DEPTH(NUM_BUFFERS)) u_flag_ram (
    .clk (clk),
    .we  (wr.flag_we),
    .wa  (flag_wa),
    .wd  (wr.flag_wd),
    .re  (rd_en),
    .ra  (rd_addr),
    .rd  (flag_rd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= res;
    end
  end

endmodule

// ----- rtl/bflm_ram.sv -----
// ----------------------------------------------------------------------------
// bflm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bflm_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wa,
  input  logic [WIDTH-1:0]  wd,
  input  logic              re,
  input  logic [ADDR_W-1:0] ra,
  output logic [WIDTH-1:0]  rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// ----- rtl/bflm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bflm_ctrl
// Sequencer for the free list: membership check, head and tail pointers,
// link updates and the clearing pass over the membership memory.
// ----------------------------------------------------------------------------
module bflm_ctrl
  import bflm_pkg::*;
#(
  parameter int NUM_BUFFERS = 64,
  localparam int ADDR_W = $clog2(NUM_BUFFERS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [OP_W-1:0]   req_op,
  input  logic [IDX_W-1:0]  req_idx,
  output logic              req_ready,
  input  logic [IDX_W-1:0]  next_rd,
  input  logic [IDX_W-1:0]  prev_rd,
  input  logic              flag_rd,
  input  logic              out_free,
  output logic              res_valid,
  output res_t              res,
  output wr_t               wr,
  output logic [ADDR_W-1:0] next_wa,
  output logic [ADDR_W-1:0] prev_wa,
  output logic [ADDR_W-1:0] flag_wa,
  output logic [IDX_W-1:0]  next_wd,
  output logic [IDX_W-1:0]  prev_wd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic              state;
  logic              clearing;
  logic [ADDR_W-1:0] clr_cnt;
  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  b_q;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic              empty;

  logic [IDX_W-1:0]  head_next;
  logic [IDX_W-1:0]  tail_next;
  logic              empty_next;
  logic              ok;
  logic              in_range;
  logic              fire;
  logic              accept;
  logic              nwe;
  logic              pwe;
  logic              fwe;
  logic              fwd;
  logic [IDX_W-1:0]  nwa;
  logic [IDX_W-1:0]  pwa;

  assign req_ready = !clearing && (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign fire      = (state == ST_EXEC) && out_free;
  assign in_range  = ({{(32-IDX_W){1'b0}}, b_q} < 32'(NUM_BUFFERS));

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    ok         = 1'b1;
    nwe        = 1'b0;
    pwe        = 1'b0;
    fwe        = 1'b0;
    fwd        = 1'b0;
    nwa        = b_q;
    pwa        = b_q;
    next_wd    = head;
    prev_wd    = b_q;
    case (op_q)
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (!in_range || flag_rd) begin
          ok = 1'b0;
        end else begin
          fwe = 1'b1;
          fwd = 1'b1;
          if (empty) begin
            head_next  = b_q;
            tail_next  = b_q;
            empty_next = 1'b0;
          end else if (op_q == OP_INS_HEAD) begin
            nwe       = 1'b1;
            nwa       = b_q;
            next_wd   = head;
            pwe       = 1'b1;
            pwa       = head;
            prev_wd   = b_q;
            head_next = b_q;
          end else begin
            pwe       = 1'b1;
            pwa       = b_q;
            prev_wd   = tail;
            nwe       = 1'b1;
            nwa       = tail;
            next_wd   = b_q;
            tail_next = b_q;
          end
        end
      end
      OP_REMOVE: begin
        if (!in_range || !flag_rd || empty) begin
          ok = 1'b0;
        end else if (head == tail) begin
          if (b_q != head) begin
            ok = 1'b0;
          end else begin
            fwe        = 1'b1;
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
          end
        end else begin
          fwe = 1'b1;
          if (b_q == head) begin
            head_next = next_rd;
          end else if (b_q == tail) begin
            tail_next = prev_rd;
          end else begin
            // unlink from the middle
            nwe     = 1'b1;
            nwa     = prev_rd;
            next_wd = next_rd;
            pwe     = 1'b1;
            pwa     = next_rd;
            prev_wd = prev_rd;
          end
        end
      end
      OP_PEEK: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

  assign wr.next_we = fire && nwe;
  assign wr.prev_we = fire && pwe;
  assign wr.flag_we = clearing || (fire && fwe);
  assign wr.flag_wd = !clearing && fwd;
  assign next_wa    = ADDR_W'(nwa);
  assign prev_wa    = ADDR_W'(pwa);
  assign flag_wa    = clearing ? clr_cnt : ADDR_W'(b_q);

  assign res_valid      = fire;
  assign res.status     = !ok;
  assign res.head_index = empty_next ? '0 : head_next;
  assign res.list_empty = empty_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      clearing <= 1'b1;
      clr_cnt  <= '0;
      head     <= '0;
      tail     <= '0;
      empty    <= 1'b1;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == ADDR_W'(NUM_BUFFERS - 1)) begin
          clearing <= 1'b0;
        end
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            head  <= head_next;
            tail  <= tail_next;
            empty <= empty_next;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= req_op;
      b_q  <= req_idx;
    end
  end

endmodule

// ----- rtl/bflm_checker.sv -----
// ----------------------------------------------------------------------------
// bflm_checker
// Port-level checks for the buffer free list manager, bound to the top level.
// ----------------------------------------------------------------------------
module bflm_checker
  import bflm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // busy for the update cycle after a request
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken during update cycle");

  // empty list reports head zero
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7] |-> m_tdata[6:1] == 6'd0)
    else $error("nonzero head on empty list");

  // a fresh result follows an accepted request, via the update state and the result register
  a_res_after_req: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without request");

endmodule

bind buffer_free_list_manager bflm_checker u_bflm_checker (.*);

// ----- tb/sv/buffer_free_list_manager_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buffer_free_list_manager_tb
// Self-checking bench for the free list manager. A short table of directed
// requests walks through empty, single and multi entry lists, every opcode
// and every refusal case. Random requests follow, mostly valid inserts and
// removes with random content, with some refused ones mixed in. Typed rows
// are held to their values, the rest to a local doubly linked list model.
// Both stream sides idle at random in changing proportions.
// ----------------------------------------------------------------------------
module buffer_free_list_manager_tb;
  import bflm_pkg::*;

  localparam int NUM_BUFS   = 64;
  localparam int RAND_ITEMS = 1000;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic             chk;
    res_t             res;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;   // opcode[1:0], buffer_index[7:2]
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;   // status[0], head_index[6:1], list_empty[7]

  // list model
  logic [IDX_W-1:0] fwd_link  [NUM_BUFS];
  logic [IDX_W-1:0] back_link [NUM_BUFS];
  logic             listed    [NUM_BUFS];
  logic [IDX_W-1:0] head_buf;
  logic [IDX_W-1:0] tail_buf;
  logic             list_is_empty;

  res_t      pending_results [$];
  stim_row_t directed [$];
  int        error_count   = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  buffer_free_list_manager #(
    .NUM_BUFFERS(NUM_BUFS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic insert_buf(logic [IDX_W-1:0] b, logic at_head);
    if (listed[b]) return 1'b0;
    if (list_is_empty) begin
      head_buf      = b;
      tail_buf      = b;
      list_is_empty = 1'b0;
    end else if (at_head) begin
      fwd_link[b]         = head_buf;
      back_link[head_buf] = b;
      head_buf            = b;
    end else begin
      back_link[b]       = tail_buf;
      fwd_link[tail_buf] = b;
      tail_buf           = b;
    end
    listed[b] = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic remove_buf(logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] n;
    if (!listed[b] || list_is_empty) return 1'b0;
    if (head_buf == tail_buf) begin
      if (b != head_buf) return 1'b0;
      head_buf      = '0;
      tail_buf      = '0;
      list_is_empty = 1'b1;
    end else if (b == head_buf) begin
      head_buf = fwd_link[b];
    end else if (b == tail_buf) begin
      tail_buf = back_link[b];
    end else begin
      p            = back_link[b];
      n            = fwd_link[b];
      fwd_link[p]  = n;
      back_link[n] = p;
    end
    listed[b] = 1'b0;
    return 1'b1;
  endfunction

  function automatic res_t apply_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] b);
    logic ok;
    res_t r;
    ok = 1'b1;
    case (op)
      OP_INS_HEAD: ok = insert_buf(b, 1'b1);
      OP_INS_TAIL: ok = insert_buf(b, 1'b0);
      OP_REMOVE:   ok = remove_buf(b);
      default:     ok = 1'b1;
    endcase
    r.status     = !ok;
    r.head_index = list_is_empty ? '0 : head_buf;
    r.list_empty = list_is_empty;
    return r;
  endfunction

  // random buffer, biased toward the wanted membership
  function automatic logic [IDX_W-1:0] pick_buffer(logic want_listed);
    logic [IDX_W-1:0] b;
    b = IDX_W'($urandom_range(NUM_BUFS - 1));
    for (int k = 0; k < 32 && listed[b] != want_listed; k++) begin
      b = IDX_W'($urandom_range(NUM_BUFS - 1));
    end
    return b;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                         input logic chk, input logic st, input logic [IDX_W-1:0] hd,
                         input logic em);
    stim_row_t row;
    row.op             = op;
    row.idx            = idx;
    row.chk            = chk;
    row.res.status     = st;
    row.res.head_index = hd;
    row.res.list_empty = em;
    directed.push_back(row);
  endtask

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic chk, input res_t typed_res);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {idx, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_request(op, idx);
    pending_results.push_back(chk ? typed_res : r);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, got.status);
          error_count++;
        end
        if (got.head_index !== want.head_index) begin
          $display("%0t: head_index mismatch, expected %0d actual %0d",
                   $time, want.head_index, got.head_index);
          error_count++;
        end
        if (got.list_empty !== want.list_empty) begin
          $display("%0t: list_empty mismatch, expected %0d actual %0d",
                   $time, want.list_empty, got.list_empty);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    int               r;
    int               grow_pct;
    int               regime_left;
    res_t             none;

    none     = '0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    for (int i = 0; i < NUM_BUFS; i++) begin
      fwd_link[i]  = '0;
      back_link[i] = '0;
      listed[i]    = 1'b0;
    end
    head_buf      = '0;
    tail_buf      = '0;
    list_is_empty = 1'b1;

    // op, buffer, typed check, status, head, empty
    add_row(OP_PEEK,     6'd0,  1'b1, 1'b0, 6'd0,  1'b1);
    add_row(OP_REMOVE,   6'd0,  1'b1, 1'b1, 6'd0,  1'b1);
    add_row(OP_INS_HEAD, 6'd0,  1'b1, 1'b0, 6'd0,  1'b0);
    add_row(OP_INS_TAIL, 6'd63, 1'b1, 1'b0, 6'd0,  1'b0);
    add_row(OP_INS_HEAD, 6'd21, 1'b1, 1'b0, 6'd21, 1'b0);
    add_row(OP_INS_TAIL, 6'd42, 1'b1, 1'b0, 6'd21, 1'b0);
    add_row(OP_INS_HEAD, 6'd63, 1'b1, 1'b1, 6'd21, 1'b0);
    add_row(OP_INS_TAIL, 6'd0,  1'b1, 1'b1, 6'd21, 1'b0);
    add_row(OP_PEEK,     6'd63, 1'b1, 1'b0, 6'd21, 1'b0);
    add_row(OP_REMOVE,   6'd0,  1'b1, 1'b0, 6'd21, 1'b0);
    add_row(OP_REMOVE,   6'd0,  1'b1, 1'b1, 6'd21, 1'b0);
    add_row(OP_REMOVE,   6'd21, 1'b1, 1'b0, 6'd63, 1'b0);
    add_row(OP_REMOVE,   6'd42, 1'b1, 1'b0, 6'd63, 1'b0);
    add_row(OP_REMOVE,   6'd5,  1'b1, 1'b1, 6'd63, 1'b0);
    add_row(OP_REMOVE,   6'd63, 1'b1, 1'b0, 6'd0,  1'b1);
    add_row(OP_REMOVE,   6'd63, 1'b1, 1'b1, 6'd0,  1'b1);
    add_row(OP_INS_TAIL, 6'd42, 1'b1, 1'b0, 6'd42, 1'b0);
    add_row(OP_INS_HEAD, 6'd21, 1'b0, 1'b0, 6'd0,  1'b0);
    add_row(OP_INS_HEAD, 6'd63, 1'b0, 1'b0, 6'd0,  1'b0);
    add_row(OP_REMOVE,   6'd21, 1'b0, 1'b0, 6'd0,  1'b0);
    add_row(OP_REMOVE,   6'd63, 1'b0, 1'b0, 6'd0,  1'b0);
    add_row(OP_INS_TAIL, 6'd1,  1'b0, 1'b0, 6'd0,  1'b0);
    add_row(OP_REMOVE,   6'd1,  1'b0, 1'b0, 6'd0,  1'b0);
    add_row(OP_REMOVE,   6'd42, 1'b1, 1'b0, 6'd0,  1'b1);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 25;
    recv_idle_pct = 84;
    foreach (directed[i]) begin
      send_request(directed[i].op, directed[i].idx, directed[i].chk, directed[i].res);
    end

    grow_pct    = 85;
    regime_left = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 25;
      end else if (n == 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // alternate filling and draining stretches
      if (regime_left == 0) begin
        regime_left = $urandom_range(150, 20);
        grow_pct    = (grow_pct > 50) ? 15 : 85;
      end
      regime_left--;
      r = $urandom_range(99);
      if (r < 8) begin
        op  = OP_PEEK;
        idx = IDX_W'($urandom_range(NUM_BUFS - 1));
      end else begin
        if ($urandom_range(99) < grow_pct) begin
          op = $urandom_range(1) ? OP_INS_HEAD : OP_INS_TAIL;
        end else begin
          op = OP_REMOVE;
        end
        if (r < 18) begin
          idx = IDX_W'($urandom_range(NUM_BUFS - 1));
        end else begin
          idx = pick_buffer(op == OP_REMOVE);
        end
      end
      send_request(op, idx, 1'b0, none);
    end
    s_tvalid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
